### hdl/cgs_pkg.sv
// shared types and constants for the conjugate gradient solver
package cgs_pkg;

   localparam int MAX_SIZE = 16;
   localparam int IDX_W    = $clog2(MAX_SIZE);
   localparam int CNT_W    = IDX_W + 1;

   // transaction kinds
   localparam logic [1:0] REQ_MATRIX = 2'd0;
   localparam logic [1:0] REQ_RHS    = 2'd1;
   localparam logic [1:0] REQ_GUESS  = 2'd2;
   localparam logic [1:0] REQ_START  = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_SIZE  = 2'd0;
   localparam logic [1:0] CSR_ITERS = 2'd1;
   localparam logic [1:0] CSR_THRESH = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MV_MUL,
      ST_MV_ACC,
      ST_MV_DRAIN,
      ST_MV_WR,
      ST_INIT_DIR,
      ST_GRAD,
      ST_DOT_MUL,
      ST_DOT_ACC,
      ST_DOT_DRAIN,
      ST_CHECK,
      ST_DIV,
      ST_DIV_END,
      ST_BETA_MUL,
      ST_BETA_WR,
      ST_STEP_MUL,
      ST_STEP_WR,
      ST_EMIT
   } state_type;

   // which matrix-vector / dot product is running
   typedef enum logic [2:0] {
      PH_INIT,
      PH_GRAD,
      PH_NORM,
      PH_NUM,
      PH_AD,
      PH_DEN
   } phase_type;

   // saturate a 64-bit value to 32 bits
   function automatic logic [32:0] sat32(input logic signed [63:0] v);
      logic [32:0] r;
      if (v > 64'sd2147483647)       r = {1'b1, 32'h7fffffff};
      else if (v < -64'sd2147483648) r = {1'b1, 32'h80000000};
      else                           r = {1'b0, v[31:0]};
      return r;
   endfunction

   // saturating 64-bit add, flag in msb
   function automatic logic [64:0] add64(input logic signed [63:0] a,
                                         input logic signed [63:0] b);
      logic signed [64:0] s;
      logic [64:0] r;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) r = {1'b1, s[64] ? 64'h8000000000000000 : 64'h7fffffffffffffff};
      else                r = {1'b0, s[63:0]};
      return r;
   endfunction

endpackage

### hdl/conjugate_gradient_solver_unit.sv
// conjugate gradient solver top level with shared multiplier and divider
//
// Usage: req_ transactions load A[row][col] (req_type 0), b[row] (1) and the
// start guess x[row] (2). A start transaction (req_type 3) runs up to
// max_iterations conjugate gradient iterations and then emits n = active_size
// rsp_ transactions, x[0] .. x[n-1], with last on the final one and
// converged, iterations and saturated on all of them.
// One multiplier (32x32, registered operands and product) and one restoring
// divider (one quotient bit per cycle) are shared under a sequencer.
// req_ready is low for the whole solve and while results are emitted, and
// high again the cycle after the last result is taken.
// Reset (synchronous, active high) returns the sequencer to idle and the
// registers to size 16, limit 4, threshold 66; stores are undefined until
// written. A stalled rsp_ready holds the current result; nothing is lost.
module conjugate_gradient_solver_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_type,
   input  logic [3:0]                req_row,
   input  logic [3:0]                req_col,
   input  logic signed [31:0]        req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [3:0]                rsp_index,
   output logic signed [31:0]        rsp_element,
   output logic                      rsp_last,
   output logic                      rsp_converged,
   output logic [7:0]                rsp_iterations,
   output logic                      rsp_saturated,
   input  logic                      csr_write,
   input  logic [1:0]                csr_index,
   input  logic [31:0]               csr_data
);
   import cgs_pkg::*;

   // configuration registers
   logic [4:0]  size_ff;
   logic [7:0]  maxit_ff;
   logic [31:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= 5'd16;
         maxit_ff  <= 8'd4;
         thresh_ff <= 32'd66;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SIZE:   size_ff   <= csr_data[4:0];
            CSR_ITERS:  maxit_ff  <= csr_data[7:0];
            CSR_THRESH: thresh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stores
   logic signed [31:0] mat_mem [MAX_SIZE*MAX_SIZE];
   logic signed [31:0] rhs_mem [MAX_SIZE];
   logic signed [31:0] x_mem   [MAX_SIZE];
   logic signed [31:0] d_mem   [MAX_SIZE];
   logic signed [31:0] g_mem   [MAX_SIZE];
   logic signed [31:0] p_mem   [MAX_SIZE];

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [7:0]  t_ff, t_in;
   logic        conv_ff, conv_in, sat_ff, sat_in;
   logic signed [63:0] acc_ff, acc_in, prev_ff, prev_in, num_ff, num_in;
   logic signed [63:0] prod_ff;
   logic signed [31:0] opa_ff, opb_ff;
   logic signed [31:0] beta_ff, beta_in, s_ff, s_in;
   // divider
   logic [63:0] dn_ff, dn_in, dd_ff, dd_in, rem_ff, rem_in;
   logic [47:0] q_ff, q_in;
   logic        qovf_ff, qovf_in;
   logic [6:0]  dk_ff, dk_in;
   logic        dneg_ff, dneg_in;
   logic [IDX_W-1:0] oi_ff, oi_in;
   // valid flags following the two multiplier stages
   logic [1:0] acc_pipe_ff;

   // combinational write controls
   logic               mem_we;
   logic [2:0]         mem_sel;
   logic signed [31:0] mem_wd;
   logic               ld_a, ld_b;

   logic lastidx_j, lastidx_i;
   assign lastidx_j = ({1'b0, j_ff} == n_ff - 1'b1);
   assign lastidx_i = ({1'b0, i_ff} == n_ff - 1'b1);

   // vector operands for the shared multiplier
   logic signed [31:0] fa, fb;
   always_comb begin
      fa = '0;
      fb = '0;
      case (state_ff)
         ST_MV_MUL: begin
            fb = (phase_ff == PH_AD) ? d_mem[j_ff] : x_mem[j_ff];
         end
         ST_DOT_MUL: begin
            case (phase_ff)
               PH_NORM: begin fa = g_mem[i_ff]; fb = g_mem[i_ff]; end
               PH_NUM:  begin fa = d_mem[i_ff]; fb = g_mem[i_ff]; end
               default: begin fa = d_mem[i_ff]; fb = p_mem[i_ff]; end
            endcase
         end
         ST_BETA_MUL: begin fa = beta_ff; fb = d_mem[i_ff]; end
         ST_STEP_MUL: begin fa = s_ff; fb = d_mem[i_ff]; end
         default: ;
      endcase
   end

   // operand register (registered matrix read) then product register
   logic run_mul;
   assign run_mul = (state_ff == ST_MV_MUL) || (state_ff == ST_DOT_MUL) ||
                    (state_ff == ST_BETA_MUL) || (state_ff == ST_STEP_MUL);
   always_ff @(posedge clock) begin
      if (run_mul) begin
         opa_ff <= (state_ff == ST_MV_MUL) ? mat_mem[{i_ff, j_ff}] : fa;
         opb_ff <= fb;
      end
      prod_ff <= opa_ff * opb_ff;
   end

   logic [64:0] acc_sum;
   assign acc_sum = add64(acc_ff, prod_ff);
   logic signed [63:0] fl;
   assign fl = acc_ff >>> 16;
   logic [64:0] bd_sum;
   assign bd_sum = add64(-{{32{g_mem[i_ff][31]}}, g_mem[i_ff]}, prod_ff >>> 16);
   logic [32:0] sat_a, sat_b, sat_c, sat_d, sat_e;
   assign sat_a = sat32(fl);
   assign sat_b = sat32(64'(rhs_mem[i_ff]) - 64'(p_mem[i_ff]));
   assign sat_c = sat32(64'(p_mem[i_ff]) - 64'(rhs_mem[i_ff]));
   assign sat_d = sat32(bd_sum[63:0]);
   assign sat_e = sat32(64'(x_mem[i_ff]) + (prod_ff >>> 16));

   // next dividend bit: 64 bits of the dividend, then 16 zero fraction bits
   logic        nb;
   assign nb = (dk_ff < 7'd64) ? dn_ff[6'd63 - dk_ff[5:0]] : 1'b0;
   logic [64:0] sub_try;
   assign sub_try = {rem_ff, nb} - {1'b0, dd_ff};
   logic [31:0] qlim;
   assign qlim = dneg_ff ? 32'h80000000 : 32'h7fffffff;

   always_comb begin
      state_in = state_ff; phase_in = phase_ff;
      i_in = i_ff; j_in = j_ff; n_in = n_ff; t_in = t_ff;
      conv_in = conv_ff; sat_in = sat_ff;
      acc_in = acc_ff; prev_in = prev_ff; num_in = num_ff;
      beta_in = beta_ff; s_in = s_ff;
      dn_in = dn_ff; dd_in = dd_ff; rem_in = rem_ff; q_in = q_ff; qovf_in = qovf_ff;
      dk_in = dk_ff; dneg_in = dneg_ff; oi_in = oi_ff;
      mem_we = 1'b0; mem_sel = 3'd0; mem_wd = '0;
      ld_a = 1'b0; ld_b = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_type)
                  REQ_MATRIX: ld_a = 1'b1;
                  REQ_RHS:    ld_b = 1'b1;
                  REQ_GUESS: begin
                     mem_we = 1'b1; mem_sel = 3'd0; mem_wd = req_value;
                  end
                  default: begin
                     n_in = (size_ff == 5'd0) ? CNT_W'(1) :
                            (size_ff > 5'(MAX_SIZE)) ? CNT_W'(MAX_SIZE) : CNT_W'(size_ff);
                     sat_in = 1'b0; conv_in = 1'b0; t_in = '0;
                     i_in = '0; j_in = '0; acc_in = '0;
                     phase_in = PH_INIT; state_in = ST_MV_MUL;
                  end
               endcase
            end
         end
         ST_MV_MUL: begin
            // issue one product per cycle of the row
            if (lastidx_j) state_in = ST_MV_ACC;
            else j_in = j_ff + 1'b1;
         end
         ST_MV_ACC:   state_in = ST_MV_DRAIN;
         ST_MV_DRAIN: state_in = ST_MV_WR;
         ST_MV_WR: begin
            // product_store entry = sat(floor(row sum))
            mem_we = 1'b1; mem_sel = 3'd4; mem_wd = sat_a[31:0];
            sat_in = sat_ff | sat_a[32];
            acc_in = '0; j_in = '0;
            if (lastidx_i) begin
               i_in = '0;
               case (phase_ff)
                  PH_INIT: state_in = ST_INIT_DIR;
                  PH_GRAD: state_in = ST_GRAD;
                  default: begin phase_in = PH_DEN; state_in = ST_DOT_MUL; end
               endcase
            end else begin
               i_in = i_ff + 1'b1; state_in = ST_MV_MUL;
            end
         end
         ST_INIT_DIR: begin
            mem_we = 1'b1; mem_sel = 3'd2; mem_wd = sat_b[31:0];
            sat_in = sat_ff | sat_b[32];
            if (lastidx_i) begin
               i_in = '0;
               if (t_ff == maxit_ff) state_in = ST_EMIT;
               else begin phase_in = PH_GRAD; state_in = ST_MV_MUL; end
            end else i_in = i_ff + 1'b1;
         end
         ST_GRAD: begin
            mem_we = 1'b1; mem_sel = 3'd3; mem_wd = sat_c[31:0];
            sat_in = sat_ff | sat_c[32];
            if (lastidx_i) begin
               i_in = '0; phase_in = PH_NORM; state_in = ST_DOT_MUL;
            end else i_in = i_ff + 1'b1;
         end
         ST_DOT_MUL: begin
            if (lastidx_i) state_in = ST_DOT_ACC;
            else i_in = i_ff + 1'b1;
         end
         ST_DOT_ACC:   state_in = ST_DOT_DRAIN;
         ST_DOT_DRAIN: state_in = ST_CHECK;
         ST_CHECK: begin
            i_in = '0;
            acc_in = '0;
            case (phase_ff)
               PH_NORM: begin
                  prev_in = acc_ff;
                  num_in  = prev_ff;
                  if (acc_ff < $signed({16'd0, thresh_ff, 16'd0})) begin
                     conv_in = 1'b1; state_in = ST_EMIT;
                  end else if (t_ff != 8'd0) begin
                     // beta = g.g / previous
                     dn_in = acc_ff[63] ? -acc_ff : acc_ff;
                     dd_in = prev_ff[63] ? -prev_ff : prev_ff;
                     dneg_in = acc_ff[63] ^ prev_ff[63];
                     rem_in = '0; q_in = '0; qovf_in = 1'b0; dk_in = '0;
                     state_in = ST_DIV;
                  end else begin
                     phase_in = PH_NUM; state_in = ST_DOT_MUL;
                  end
               end
               PH_NUM: begin
                  num_in = acc_ff;
                  phase_in = PH_AD; j_in = '0; state_in = ST_MV_MUL;
               end
               default: begin
                  // s = -num/den
                  dn_in = num_ff[63] ? -num_ff : num_ff;
                  dd_in = acc_ff[63] ? -acc_ff : acc_ff;
                  dneg_in = ~(num_ff[63] ^ acc_ff[63]);
                  rem_in = '0; q_in = '0; qovf_in = 1'b0; dk_in = '0;
                  state_in = ST_DIV;
               end
            endcase
         end
         ST_DIV: begin
            // one quotient bit per cycle: 64 integer bits then 16 fraction bits
            // quotient bits above the kept 48 only need to be flagged
            if (!sub_try[64]) begin
               rem_in = sub_try[63:0];
               q_in = {q_ff[46:0], 1'b1};
            end else begin
               rem_in = {rem_ff[62:0], nb};
               q_in = {q_ff[46:0], 1'b0};
            end
            qovf_in = qovf_ff | q_ff[47];
            dk_in = dk_ff + 1'b1;
            if (dk_ff == 7'd79) state_in = ST_DIV_END;
         end
         ST_DIV_END: begin
            if (dd_ff == 64'd0) begin
               sat_in = 1'b1;
               beta_in = (dn_ff == 64'd0) ? 32'd0 : qlim;
            end else if (qovf_ff || (q_ff > 48'(qlim))) begin
               sat_in = 1'b1;
               beta_in = qlim;
            end else begin
               beta_in = dneg_ff ? -q_ff[31:0] : q_ff[31:0];
            end
            s_in = beta_in;
            if (phase_ff == PH_NORM) begin
               s_in = s_ff; state_in = ST_BETA_MUL;
            end else begin
               beta_in = beta_ff; state_in = ST_STEP_MUL;
            end
            i_in = '0;
            dk_in = '0;
         end
         ST_BETA_MUL: state_in = ST_BETA_WR;
         ST_BETA_WR: begin
            // the first pass only sets dk; the write waits for the registered product
            if (dk_ff == 7'd0) begin
               dk_in = 7'd1;
            end else begin
               dk_in = '0;
               mem_we = 1'b1; mem_sel = 3'd2; mem_wd = sat_d[31:0];
               sat_in = sat_ff | sat_d[32] | bd_sum[64];
               if (lastidx_i) begin
                  i_in = '0; phase_in = PH_NUM; state_in = ST_DOT_MUL;
               end else begin
                  i_in = i_ff + 1'b1; state_in = ST_BETA_MUL;
               end
            end
         end
         ST_STEP_MUL: state_in = ST_STEP_WR;
         ST_STEP_WR: begin
            if (dk_ff == 7'd0) begin
               dk_in = 7'd1;
            end else begin
               dk_in = '0;
               mem_we = 1'b1; mem_sel = 3'd0; mem_wd = sat_e[31:0];
               sat_in = sat_ff | sat_e[32];
               if (lastidx_i) begin
                  i_in = '0; t_in = t_ff + 1'b1;
                  if (t_ff + 1'b1 == maxit_ff) state_in = ST_EMIT;
                  else begin phase_in = PH_GRAD; state_in = ST_MV_MUL; end
               end else begin
                  i_in = i_ff + 1'b1; state_in = ST_STEP_MUL;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if ({1'b0, oi_ff} == n_ff - 1'b1) begin
                  oi_in = '0; state_in = ST_IDLE;
               end else oi_in = oi_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // accumulate while products drain
      if (acc_pipe_ff[1]) begin
         acc_in = acc_sum[63:0];
         sat_in = sat_in | acc_sum[64];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) acc_pipe_ff <= '0;
      else acc_pipe_ff <= {acc_pipe_ff[0],
                           (state_ff == ST_MV_MUL) || (state_ff == ST_DOT_MUL)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         oi_ff    <= '0;
         dk_ff    <= '0;
         prev_ff  <= '0;
         sat_ff   <= 1'b0;
         conv_ff  <= 1'b0;
         t_ff     <= '0;
      end else begin
         state_ff <= state_in;
         oi_ff    <= oi_in;
         dk_ff    <= dk_in;
         prev_ff  <= prev_in;
         sat_ff   <= sat_in;
         conv_ff  <= conv_in;
         t_ff     <= t_in;
      end
      phase_ff <= phase_in;
      i_ff <= i_in; j_ff <= j_in; n_ff <= n_in;
      acc_ff <= acc_in; num_ff <= num_in;
      beta_ff <= beta_in; s_ff <= s_in;
      dn_ff <= dn_in; dd_ff <= dd_in; rem_ff <= rem_in; q_ff <= q_in;
      qovf_ff <= qovf_in;
      dneg_ff <= dneg_in;
   end

   // store writes
   always_ff @(posedge clock) begin
      if (ld_a) mat_mem[{req_row, req_col}] <= req_value;
      if (ld_b) rhs_mem[req_row] <= req_value;
      if (mem_we) begin
         case (mem_sel)
            3'd0: x_mem[(state_ff == ST_IDLE) ? req_row : i_ff] <= mem_wd;
            3'd2: d_mem[i_ff] <= mem_wd;
            3'd3: g_mem[i_ff] <= mem_wd;
            default: p_mem[i_ff] <= mem_wd;
         endcase
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = (state_ff == ST_EMIT);
   assign rsp_index      = oi_ff;
   assign rsp_element    = x_mem[oi_ff];
   assign rsp_last       = ({1'b0, oi_ff} == n_ff - 1'b1);
   assign rsp_converged  = conv_ff;
   assign rsp_iterations = conv_ff ? t_ff : maxit_ff;
   assign rsp_saturated  = sat_ff;

endmodule

### hdl/cgs_checker.sv
// port-level checks for the conjugate gradient solver
module cgs_port_checks (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_last,
   input logic [3:0] rsp_index
);
   // never accepting while results are offered
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while emitting");
   // stalled result holds its index
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index))
      else $error("result changed under stall");
   // index steps by one inside a run
   a_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_index == $past(rsp_index) + 4'd1)
      else $error("index skipped");
   // a run ends at last and the unit goes idle
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready)
      else $error("not idle after last");
endmodule

bind conjugate_gradient_solver_unit cgs_port_checks u_cgs_port_checks (.*);
